FILE: hdl/hdrid_pkg.sv
package hdrid_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PAGE_W     = 16;
    localparam int unsigned SKIP_W     = 9;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [BYTE_W-1:0] LONG_PREFIX    = 8'hFE;
    localparam logic [BYTE_W-1:0] TAG_USAGE_PAGE = 8'h04;
    localparam logic [BYTE_W-1:0] TAG_REPORT_ID  = 8'h84;
    localparam logic [BYTE_W-1:0] TAG_MASK       = 8'hFC;

    localparam logic [PAGE_W-1:0] CMD_PAGE_RST = 16'hFF00;
    localparam logic [PAGE_W-1:0] ALT_PAGE_RST = 16'h00FF;

    // command channel report ids
    localparam logic [BYTE_W-1:0] RID_CMD_0 = 8'h0E;
    localparam logic [BYTE_W-1:0] RID_CMD_1 = 8'h0F;
    localparam logic [BYTE_W-1:0] RID_CMD_2 = 8'h10;
    localparam logic [BYTE_W-1:0] RID_CMD_3 = 8'h11;
    // image channel report ids
    localparam logic [BYTE_W-1:0] RID_IMG_0 = 8'h0C;
    localparam logic [BYTE_W-1:0] RID_IMG_1 = 8'h0D;
    localparam logic [BYTE_W-1:0] RID_IMG_2 = 8'h20;
    localparam logic [BYTE_W-1:0] RID_IMG_3 = 8'h21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CMD_PAGE = 1'b0,
        REG_ALT_PAGE = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_PREFIX     = 2'd0,
        PH_LONG_SIZE  = 2'd1,
        PH_LONG_SKIP  = 2'd2,
        PH_SHORT_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] desc_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic cmd_reports_found;
        logic img_reports_found;
    } t_out_item;

endpackage

FILE: hdl/hid_descriptor_report_id_scanner.sv
// Channel   Dir  Handshake                Payload
// -------   ---  ---------                -------
// in        in   i_in_valid / o_in_ready   i_in  (desc_byte, last_byte)
// out       out  o_out_valid / i_out_ready o_out (cmd/img reports found)
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One descriptor byte per cycle while o_in_ready is high: the parse state is updated at the same edge
// that accepts the byte; the result register loads on a last byte.
// o_out_valid rises in the cycle after the last byte is accepted.
// o_in_ready is low only while a result waits in the output register and the
// sink is stalling; a taken result frees the register in the same cycle.
// Reset (synchronous, active low) clears the parse state and loads the
// default usage pages. Config writes are always ready.
module hid_descriptor_report_id_scanner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  hdrid_pkg::t_in_item                i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output hdrid_pkg::t_out_item               o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hdrid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hdrid_pkg::PAGE_W-1:0]       i_cfg_data
);
    import hdrid_pkg::*;

    // configuration
    logic [PAGE_W-1:0] r_cmd_page;
    logic [PAGE_W-1:0] r_alt_page;

    // parse state
    t_phase            r_phase,      n_phase;
    logic [SKIP_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_item_tag,   n_item_tag;
    logic [1:0]        r_data_index, n_data_index;
    logic [PAGE_W-1:0] r_value_low,  n_value_low;
    logic [PAGE_W-1:0] r_usage_page, n_usage_page;
    logic [3:0]        r_cmd_seen,   n_cmd_seen;
    logic [3:0]        r_img_seen,   n_img_seen;

    // result register
    logic              r_out_valid,  n_out_valid;
    t_out_item         r_out,        n_out;

    logic              in_acc;
    logic              apply_en;
    logic [BYTE_W-1:0] apply_tag;
    logic [PAGE_W-1:0] apply_val;
    logic [BYTE_W-1:0] rid;
    logic              cmd_page_hit;
    logic              img_page_hit;
    logic [1:0]        size_code;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_page <= CMD_PAGE_RST;
            r_alt_page <= ALT_PAGE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CMD_PAGE: r_cmd_page <= i_cfg_data;
                REG_ALT_PAGE: r_alt_page <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Byte decode: walk one step of the item grammar, then apply a finished
    // short item against the current usage page.
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_item_tag   = r_item_tag;
        n_data_index = r_data_index;
        n_value_low  = r_value_low;
        n_usage_page = r_usage_page;
        n_cmd_seen   = r_cmd_seen;
        n_img_seen   = r_img_seen;
        apply_en     = 1'b0;
        apply_tag    = r_item_tag;
        apply_val    = '0;
        size_code    = i_in.desc_byte[1:0];

        case (r_phase)
            PH_PREFIX: begin
                if (i_in.desc_byte == LONG_PREFIX) begin
                    n_phase = PH_LONG_SIZE;
                end else begin
                    n_item_tag = i_in.desc_byte & TAG_MASK;
                    if (size_code == 2'd0) begin
                        apply_en  = 1'b1;
                        apply_tag = i_in.desc_byte & TAG_MASK;
                    end else begin
                        // size code 3 means four data bytes
                        n_bytes_left = (size_code == 2'd3) ? SKIP_W'(4)
                                                           : SKIP_W'(size_code);
                        n_data_index = '0;
                        n_value_low  = '0;
                        n_phase      = PH_SHORT_DATA;
                    end
                end
            end
            PH_LONG_SIZE: begin
                // skip the long item tag byte plus its data
                n_bytes_left = SKIP_W'(1) + SKIP_W'(i_in.desc_byte);
                n_phase      = PH_LONG_SKIP;
            end
            PH_LONG_SKIP: begin
                if (r_bytes_left <= SKIP_W'(1)) begin
                    n_bytes_left = '0;
                    n_phase      = PH_PREFIX;
                end else begin
                    n_bytes_left = r_bytes_left - SKIP_W'(1);
                end
            end
            PH_SHORT_DATA: begin
                // only the low two data bytes are kept
                if (r_data_index == 2'd0) begin
                    n_value_low[7:0] = r_value_low[7:0] | i_in.desc_byte;
                end else if (r_data_index == 2'd1) begin
                    n_value_low[15:8] = r_value_low[15:8] | i_in.desc_byte;
                end
                n_data_index = r_data_index + 2'd1;
                if (r_bytes_left <= SKIP_W'(1)) begin
                    n_bytes_left = '0;
                    n_phase      = PH_PREFIX;
                    apply_en     = 1'b1;
                    apply_val    = n_value_low;
                end else begin
                    n_bytes_left = r_bytes_left - SKIP_W'(1);
                end
            end
            default: n_phase = PH_PREFIX;
        endcase

        rid          = apply_val[BYTE_W-1:0];
        cmd_page_hit = (r_usage_page == r_cmd_page);
        img_page_hit = cmd_page_hit || (r_usage_page == r_alt_page);

        if (apply_en) begin
            if (apply_tag == TAG_USAGE_PAGE) begin
                n_usage_page = apply_val;
            end else if (apply_tag == TAG_REPORT_ID) begin
                if (cmd_page_hit) begin
                    n_cmd_seen = r_cmd_seen | {rid == RID_CMD_3, rid == RID_CMD_2,
                                               rid == RID_CMD_1, rid == RID_CMD_0};
                end
                if (img_page_hit) begin
                    n_img_seen = r_img_seen | {rid == RID_IMG_3, rid == RID_IMG_2,
                                               rid == RID_IMG_1, rid == RID_IMG_0};
                end
            end
        end

        // result register: load on a last byte, drain when taken
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (in_acc && i_in.last_byte) begin
            n_out_valid             = 1'b1;
            n_out.cmd_reports_found = &n_cmd_seen;
            n_out.img_reports_found = &n_img_seen;
            // descriptor done: back to a clean parse
            n_phase      = PH_PREFIX;
            n_bytes_left = '0;
            n_item_tag   = '0;
            n_data_index = '0;
            n_value_low  = '0;
            n_usage_page = '0;
            n_cmd_seen   = '0;
            n_img_seen   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_bytes_left <= '0;
            r_item_tag   <= '0;
            r_data_index <= '0;
            r_value_low  <= '0;
            r_usage_page <= '0;
            r_cmd_seen   <= '0;
            r_img_seen   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_item_tag   <= n_item_tag;
                r_data_index <= n_data_index;
                r_value_low  <= n_value_low;
                r_usage_page <= n_usage_page;
                r_cmd_seen   <= n_cmd_seen;
                r_img_seen   <= n_img_seen;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // a last byte leaves a clean parse behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last_byte) |=>
            (r_phase == PH_PREFIX && r_cmd_seen == 4'd0 && r_img_seen == 4'd0))
        else $error("parse state not cleared after last byte");

    // short item data count stays within one to four bytes
    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SHORT_DATA) |-> (r_bytes_left != '0 && r_bytes_left <= SKIP_W'(4)))
        else $error("short item byte count out of range");

    // no pending skip or data count while waiting for a prefix or size byte
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PREFIX || r_phase == PH_LONG_SIZE) |-> (r_bytes_left == '0))
        else $error("byte count left over outside an item body");

    // a result only follows an accepted last byte
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && i_in.last_byte))
        else $error("result without a last byte");

endmodule

FILE: tb/tb_hid_descriptor_report_id_scanner.sv
`timescale 1ns / 1ps

module tb_hid_descriptor_report_id_scanner;

    import hdrid_pkg::*;

    // No request or result moving on any channel for this many cycles means the DUT is hung.
    localparam int STALL_LIMIT = 2000;
    // One long sink stall, so that a waiting result backs up into o_in_ready.
    localparam int LONG_HOLD   = 80;
    // Each config phase sends descriptors until both of these counts are reached.
    localparam int PHASE_BYTES = 90;
    localparam int PHASE_DESCS = 3;

    localparam logic [BYTE_W-1:0] CMD_IDS [4] = '{RID_CMD_0, RID_CMD_1, RID_CMD_2, RID_CMD_3};
    localparam logic [BYTE_W-1:0] IMG_IDS [4] = '{RID_IMG_0, RID_IMG_1, RID_IMG_2, RID_IMG_3};

    // Directed descriptors, {last_byte, desc_byte}:
    //   page 0xFF00 (two data bytes), then the four command ids -> cmd found only
    //   long item with zero data, page 0xFF from one byte, four-byte image id
    //     that completes on the last byte
    //   lone report id prefix cut off by the end
    //   zero-size main item, prefix 0xFF (four data bytes) cut off by the end
    localparam logic [8:0] DIRECTED [25] = '{
        {1'b0, 8'h06}, {1'b0, 8'h00}, {1'b0, 8'hFF},
        {1'b0, 8'h85}, {1'b0, 8'h0E}, {1'b0, 8'h85}, {1'b0, 8'h0F},
        {1'b0, 8'h85}, {1'b0, 8'h10}, {1'b0, 8'h85}, {1'b1, 8'h11},
        {1'b0, 8'hFE}, {1'b0, 8'h00}, {1'b0, 8'h5A},
        {1'b0, 8'h05}, {1'b0, 8'hFF},
        {1'b0, 8'h87}, {1'b0, 8'h0C}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},
        {1'b1, 8'h85},
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'h12}
    };

    // Every input of the DUT starts at a known value.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PAGE_W-1:0]    i_cfg_data  = '0;

    // Stimulus side.
    t_in_item          byte_q [$];      // descriptor bytes waiting for the driver
    logic [BYTE_W-1:0] desc_buf [$];    // descriptor under construction
    logic [PAGE_W-1:0] stim_cmd_page = CMD_PAGE_RST;
    logic [PAGE_W-1:0] stim_alt_page = ALT_PAGE_RST;
    int                phase_bytes   = 0;
    int                phase_descs   = 0;
    bit                quiet         = 1'b0;   // no idling on either side
    logic              in_took       = 1'b0;   // request accepted at the last rising edge
    int                in_gap        = 0;
    int                out_gap       = 0;
    int                hold_left     = 0;
    bit                hold_done     = 1'b0;

    // Predictor: a copy of the descriptor walker and its two page registers.
    t_phase            walk_phase;
    logic [SKIP_W-1:0] walk_left;
    logic [BYTE_W-1:0] walk_tag;
    logic [1:0]        walk_pos;
    logic [PAGE_W-1:0] walk_value;
    logic [PAGE_W-1:0] walk_page;
    logic [3:0]        cmd_marks;
    logic [3:0]        img_marks;
    logic [PAGE_W-1:0] model_cmd_page;
    logic [PAGE_W-1:0] model_alt_page;
    t_out_item         found_q [$];     // expected scan results, oldest first

    int                results_seen = 0;
    int                err_count    = 0;
    int                stall_cycles = 0;

    hid_descriptor_report_id_scanner DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_walk();
        walk_phase = PH_PREFIX;
        walk_left  = '0;
        walk_tag   = '0;
        walk_pos   = '0;
        walk_value = '0;
        walk_page  = '0;
        cmd_marks  = '0;
        img_marks  = '0;
    endtask

    // A finished short item: a page change or a report id to mark.
    task automatic take_item(input logic [BYTE_W-1:0] tag, input logic [PAGE_W-1:0] value);
        logic [BYTE_W-1:0] rid;
        rid = value[BYTE_W-1:0];
        if (tag == TAG_USAGE_PAGE) begin
            walk_page = value;
        end else if (tag == TAG_REPORT_ID) begin
            for (int k = 0; k < 4; k++) begin
                if (walk_page == model_cmd_page && rid == CMD_IDS[k])
                    cmd_marks[k] = 1'b1;
                if ((walk_page == model_cmd_page || walk_page == model_alt_page) &&
                    rid == IMG_IDS[k])
                    img_marks[k] = 1'b1;
            end
        end
    endtask

    // One accepted descriptor byte; a last byte queues the expected flags.
    task automatic scan_byte(input t_in_item it);
        logic [BYTE_W-1:0] b;
        b = it.desc_byte;
        case (walk_phase)
            PH_PREFIX: begin
                if (b == LONG_PREFIX) begin
                    walk_phase = PH_LONG_SIZE;
                end else begin
                    walk_tag = b & TAG_MASK;
                    if (b[1:0] == 2'd0) begin
                        take_item(walk_tag, '0);
                    end else begin
                        // size code 3 means four data bytes
                        walk_left  = (b[1:0] == 2'd3) ? SKIP_W'(4) : SKIP_W'(b[1:0]);
                        walk_pos   = '0;
                        walk_value = '0;
                        walk_phase = PH_SHORT_DATA;
                    end
                end
            end
            PH_LONG_SIZE: begin
                // long item tag byte plus the data bytes
                walk_left  = SKIP_W'(b) + 1'b1;
                walk_phase = PH_LONG_SKIP;
            end
            PH_LONG_SKIP: begin
                if (walk_left <= 1) begin
                    walk_left  = '0;
                    walk_phase = PH_PREFIX;
                end else begin
                    walk_left = walk_left - 1'b1;
                end
            end
            PH_SHORT_DATA: begin
                // bytes 2 and 3 of a four-byte item are dropped
                if (walk_pos == 2'd0)
                    walk_value[7:0] = b;
                else if (walk_pos == 2'd1)
                    walk_value[15:8] = b;
                walk_pos = walk_pos + 2'd1;
                if (walk_left <= 1) begin
                    walk_left  = '0;
                    walk_phase = PH_PREFIX;
                    take_item(walk_tag, walk_value);
                end else begin
                    walk_left = walk_left - 1'b1;
                end
            end
            default: walk_phase = PH_PREFIX;
        endcase
        if (it.last_byte) begin
            found_q.push_back(t_out_item'{cmd_reports_found: &cmd_marks,
                                          img_reports_found: &img_marks});
            clear_walk();
        end
    endtask

    // ------------------------------------------------------------------
    // Descriptor generation
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        byte_q.push_back(t_in_item'{desc_byte: b, last_byte: last});
        phase_bytes++;
    endtask

    task automatic add_short(input logic [BYTE_W-1:0] tag, input logic [1:0] code,
                             input logic [31:0] value);
        int n;
        n = (code == 2'd3) ? 4 : int'(code);
        desc_buf.push_back(tag | BYTE_W'(code));
        for (int k = 0; k < n; k++)
            desc_buf.push_back(value[8*k +: 8]);
    endtask

    // Usage page item; a page above 0xFF needs at least two data bytes.
    task automatic add_page(input logic [PAGE_W-1:0] page);
        logic [1:0] code;
        if (page == '0 && $urandom_range(0, 3) == 0)
            code = 2'd0;
        else if (page[15:8] == '0)
            code = 2'($urandom_range(1, 3));
        else
            code = 2'($urandom_range(2, 3));
        add_short(TAG_USAGE_PAGE, code, {16'($urandom), page});
    endtask

    // Report id item; junk above the low byte must be ignored.
    task automatic add_report(input logic [BYTE_W-1:0] rid);
        logic [1:0] code;
        if (rid == '0 && $urandom_range(0, 3) == 0)
            code = 2'd0;
        else
            code = 2'($urandom_range(1, 3));
        add_short(TAG_REPORT_ID, code, {24'($urandom), rid});
    endtask

    // Unrelated short item or a long item, mostly short, now and then a big one.
    task automatic add_noise();
        logic [BYTE_W-1:0] pre;
        int n;
        if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            desc_buf.push_back(LONG_PREFIX);
            desc_buf.push_back(8'(n));
            for (int k = 0; k <= n; k++)
                desc_buf.push_back(8'($urandom));
        end else begin
            do
                pre = 8'($urandom);
            while (pre == LONG_PREFIX);
            add_short(pre & TAG_MASK, pre[1:0], $urandom);
        end
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        case ($urandom_range(0, 4))
            0, 1:    return stim_cmd_page;
            2:       return stim_alt_page;
            3:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly a page plus a shuffled set of channel ids with noise between,
    // sometimes noise only; now and then cut short at a random byte.
    task automatic build_descriptor();
        logic [BYTE_W-1:0] ids [$];
        logic [BYTE_W-1:0] tmp;
        int                j;
        int                cut;
        desc_buf.delete();
        if ($urandom_range(0, 9) < 8) begin
            add_page(pick_page());
            if ($urandom_range(0, 2) != 0)
                foreach (CMD_IDS[k])
                    if ($urandom_range(0, 9) != 0)
                        ids.push_back(CMD_IDS[k]);
            if ($urandom_range(0, 2) != 0)
                foreach (IMG_IDS[k])
                    if ($urandom_range(0, 9) != 0)
                        ids.push_back(IMG_IDS[k]);
            if ($urandom_range(0, 3) == 0)
                ids.push_back(8'($urandom));
            for (int k = ids.size() - 1; k > 0; k--) begin
                j      = $urandom_range(0, k);
                tmp    = ids[k];
                ids[k] = ids[j];
                ids[j] = tmp;
            end
            foreach (ids[k]) begin
                if ($urandom_range(0, 3) == 0)
                    add_noise();
                if ($urandom_range(0, 9) == 0)
                    add_page(pick_page());
                add_report(ids[k]);
            end
        end else begin
            repeat ($urandom_range(1, 6))
                add_noise();
        end
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, desc_buf.size());
            while (desc_buf.size() > cut)
                void'(desc_buf.pop_back());
        end
        foreach (desc_buf[k])
            push_byte(desc_buf[k], k == desc_buf.size() - 1);
        phase_descs++;
    endtask

    // Queue one phase worth of descriptors, then wait for the DUT to go idle.
    // Checked at the rising edge, where the driver's queue and valid are settled.
    task automatic fill_and_drain();
        while (phase_bytes < PHASE_BYTES || phase_descs < PHASE_DESCS)
            build_descriptor();
        while (byte_q.size() != 0 || i_in_valid || o_out_valid || found_q.size() != 0)
            @(posedge i_clk);
        // idle margin after the last result is taken
        repeat (4) @(negedge i_clk);
        phase_bytes = 0;
        phase_descs = 0;
    endtask

    task automatic write_page(input t_cfg_reg idx, input logic [PAGE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_CMD_PAGE)
            stim_cmd_page = val;
        else
            stim_alt_page = val;
    endtask

    // ------------------------------------------------------------------
    // Request driver: holds a request until accepted, random idle bursts.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            // still waiting for the handshake, payload stays put
        end else if (in_gap > 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(0, 6);
            i_in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
            i_in       <= byte_q.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall bursts and one long stall while requests
    // are still queued, so the held result blocks the input side.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && !quiet && results_seen >= 4 && byte_q.size() > 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_gap = $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results against the oldest expectation, then feeds
    // config writes and accepted requests to the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            model_cmd_page = CMD_PAGE_RST;
            model_alt_page = ALT_PAGE_RST;
            clear_walk();
            found_q.delete();
            in_took      <= 1'b0;
            stall_cycles = 0;
        end else begin
            // a result can't come from a byte accepted at this same edge,
            // so compare before predicting
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (found_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                end else begin
                    want = found_q.pop_front();
                    if (o_out.cmd_reports_found !== want.cmd_reports_found)
                        report_mismatch($sformatf("result %0d cmd_reports_found %b, want %b",
                            results_seen, o_out.cmd_reports_found, want.cmd_reports_found));
                    if (o_out.img_reports_found !== want.img_reports_found)
                        report_mismatch($sformatf("result %0d img_reports_found %b, want %b",
                            results_seen, o_out.img_reports_found, want.img_reports_found));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_CMD_PAGE: model_cmd_page = i_cfg_data;
                    REG_ALT_PAGE: model_alt_page = i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                scan_byte(i_in);
            in_took <= i_in_valid && o_in_ready;

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog: nothing moving for too long.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed bytes under the reset pages, then one
    // random phase per page setting; pages change only while idle.
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [PAGE_W-1:0] pg;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k])
            push_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        fill_and_drain();

        // page extremes, both ways round
        write_page(REG_CMD_PAGE, 16'h0000);
        write_page(REG_ALT_PAGE, 16'hFFFF);
        fill_and_drain();

        write_page(REG_ALT_PAGE, 16'h0000);
        write_page(REG_CMD_PAGE, 16'hFFFF);
        fill_and_drain();

        // both pages the same
        pg = 16'($urandom);
        write_page(REG_CMD_PAGE, pg);
        write_page(REG_ALT_PAGE, pg);
        fill_and_drain();

        // random pages, full rate on both sides
        write_page(REG_CMD_PAGE, 16'($urandom));
        write_page(REG_ALT_PAGE, 16'($urandom));
        quiet = 1'b1;
        fill_and_drain();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hdrid_pkg.sv
hdl/hid_descriptor_report_id_scanner.sv
tb/tb_hid_descriptor_report_id_scanner.sv
